@@ hdl/vsoa_pkg.sv @@
// Shared constants of the vital-sign outlier-rejecting average: widths, reset values, register map.
package vsoa_pkg;

    localparam int DATA_W    = 10;
    localparam int IN_W      = 11;
    localparam int CMP_W     = 13;
    localparam int LIMIT_W   = 4;
    localparam int CFG_IDX_W = 3;

    localparam int DEF_HISTORY_DEPTH = 16;

    localparam logic [DATA_W-1:0]  RST_HR_FLOOR    = 10'd60;
    localparam logic [DATA_W-1:0]  RST_HR_CEILING  = 10'd150;
    localparam logic [DATA_W-1:0]  RST_SPO2_FLOOR  = 10'd80;
    localparam logic [DATA_W-1:0]  RST_JUMP_MARGIN = 10'd10;
    localparam logic [LIMIT_W-1:0] RST_MISS_LIMIT  = 4'd4;
    localparam logic [LIMIT_W-1:0] RST_RUN_LIMIT   = 4'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_HR_FLOOR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HR_CEILING  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPO2_FLOOR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_MARGIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LIMIT   = 3'd5;

    // Channel numbers inside the per-channel state arrays.
    localparam int CH_HR   = 0;
    localparam int CH_SPO2 = 1;

endpackage

@@ hdl/vital_sign_outlier_average.sv @@
// Vital-sign outlier-rejecting adaptive moving average, top level.
//
// One input transfer carries a heart-rate and an SpO2 reading, each with its
// own valid flag. Each reading is screened against its limits and, after a
// run of taken readings, against a jump margin versus the newest four history
// entries. A taken reading shifts into its history, and the mean over the
// newest 2, 4, 8 or 16 entries is then recomputed.
// Channels: input (i_valid / o_ready), output (o_valid / i_ready) and a
// configuration write channel (i_cfg_valid / o_cfg_ready) that is always ready.
// Throughput: an item is screened in its accept cycle, then one shared
// accumulator walks each history in turn, one entry per cycle while the
// history register rotates; the output state then moves the result into the
// output register, waiting while an earlier result is held there and not
// taken. o_ready is high only in the idle state, so the next item is
// accepted only after that move.
// Reset (synchronous, active low) clears the histories, counters and means and
// restores the register defaults. If the receiver stalls, the finished result
// waits in the output register; a new item can be accepted meanwhile, but its
// result is held back until the previous one has been transferred.
module vital_sign_outlier_average
    import vsoa_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    // Input channel.
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [IN_W-1:0] i_hr_value,
    input  logic                 i_hr_valid,
    input  logic signed [IN_W-1:0] i_spo2_value,
    input  logic                 i_spo2_valid,
    // Output channel.
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [DATA_W-1:0]    o_hr_avg,
    output logic [DATA_W-1:0]    o_spo2_avg,
    output logic                 o_hr_taken,
    output logic                 o_spo2_taken
);

    localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int IDX_W   = $clog2(HISTORY_DEPTH);
    localparam int LOG_MAX = $clog2(HISTORY_DEPTH + 1) - 1;
    localparam int SH_W    = $clog2(LOG_MAX + 1);
    localparam int ACC_W   = DATA_W + LOG_MAX;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    // Configuration registers.
    logic [DATA_W-1:0]  r_hr_floor, r_hr_ceiling, r_spo2_floor, r_jump_margin;
    logic [LIMIT_W-1:0] r_miss_limit, r_run_limit;

    // Per-channel state, index CH_HR or CH_SPO2.
    logic [DATA_W-1:0]  r_hist [2][HISTORY_DEPTH];
    logic [DATA_W-1:0]  n_hist [2][HISTORY_DEPTH];
    logic [FILL_W-1:0]  r_fill [2], n_fill [2];
    logic [LIMIT_W-1:0] r_run  [2], n_run  [2];
    logic [LIMIT_W-1:0] r_miss [2], n_miss [2];
    logic [DATA_W-1:0]  r_mean [2], n_mean [2];
    logic               r_taken[2], n_taken[2];

    // Sequencer and shared accumulator.
    logic [1:0]       r_state, n_state;
    logic             r_sel, n_sel;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [ACC_W-1:0] r_acc, n_acc;

    // Output register.
    logic              r_o_valid, n_o_valid;
    logic [DATA_W-1:0] r_o_hr_avg, n_o_hr_avg, r_o_spo2_avg, n_o_spo2_avg;
    logic              r_o_hr_taken, n_o_hr_taken, r_o_spo2_taken, n_o_spo2_taken;

    // Screening results of the presented item.
    logic signed [CMP_W-1:0] w_val [2];
    logic                    w_ok  [2];
    logic                    w_jump[2];
    logic                    w_accept;

    // Accumulator step.
    logic [SH_W-1:0]   w_sh;
    logic [FILL_W-1:0] w_thr;
    logic              w_incl;
    logic [DATA_W-1:0] w_tap;
    logic [ACC_W-1:0]  w_acc_sum;
    logic [ACC_W-1:0]  w_acc_shr;
    logic              w_last;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == ST_IDLE);
    assign w_accept    = i_valid && (r_state == ST_IDLE);

    assign o_valid      = r_o_valid;
    assign o_hr_avg     = r_o_hr_avg;
    assign o_spo2_avg   = r_o_spo2_avg;
    assign o_hr_taken   = r_o_hr_taken;
    assign o_spo2_taken = r_o_spo2_taken;

    // Limit screening and jump check against the newest four entries.
    always_comb begin
        logic signed [CMP_W-1:0] v_e;
        logic signed [CMP_W-1:0] v_m;
        w_val[CH_HR]   = CMP_W'(i_hr_value);
        w_val[CH_SPO2] = CMP_W'(i_spo2_value);
        w_ok[CH_HR]    = i_hr_valid
                         && (w_val[CH_HR] < $signed({3'b000, r_hr_ceiling}))
                         && (w_val[CH_HR] > $signed({3'b000, r_hr_floor}));
        w_ok[CH_SPO2]  = i_spo2_valid
                         && (w_val[CH_SPO2] > $signed({3'b000, r_spo2_floor}));
        v_m = $signed({3'b000, r_jump_margin});
        w_jump[CH_HR]   = 1'b0;
        w_jump[CH_SPO2] = 1'b0;
        for (int k = HISTORY_DEPTH - 4; k < HISTORY_DEPTH; k++) begin
            v_e = $signed({3'b000, r_hist[CH_HR][k]});
            if (w_val[CH_HR] < v_e + v_m) begin
                w_jump[CH_HR] = 1'b1;
            end
            v_e = $signed({3'b000, r_hist[CH_SPO2][k]});
            if (w_val[CH_SPO2] > v_e - v_m) begin
                w_jump[CH_SPO2] = 1'b1;
            end
        end
    end

    // Mean window of the channel being summed: the largest power of two
    // not above its fill count. Entries from position DEPTH - window onward
    // are added as they pass the rotation tap.
    always_comb begin
        w_sh = '0;
        for (int b = 1; b <= LOG_MAX; b++) begin
            if (r_fill[r_sel] >= FILL_W'(1 << b)) begin
                w_sh = SH_W'(b);
            end
        end
        w_thr     = FILL_W'(HISTORY_DEPTH) - (FILL_W'(1) << w_sh);
        w_incl    = (FILL_W'(r_idx) >= w_thr);
        w_tap     = r_hist[r_sel][0];
        w_acc_sum = r_acc + (w_incl ? ACC_W'(w_tap) : '0);
        w_acc_shr = w_acc_sum >> w_sh;
        w_last    = (r_idx == IDX_W'(HISTORY_DEPTH - 1));
    end

    always_comb begin
        n_state        = r_state;
        n_sel          = r_sel;
        n_idx          = r_idx;
        n_acc          = r_acc;
        n_o_valid      = r_o_valid;
        n_o_hr_avg     = r_o_hr_avg;
        n_o_spo2_avg   = r_o_spo2_avg;
        n_o_hr_taken   = r_o_hr_taken;
        n_o_spo2_taken = r_o_spo2_taken;
        n_hist         = r_hist;
        n_fill         = r_fill;
        n_run          = r_run;
        n_miss         = r_miss;
        n_mean         = r_mean;
        n_taken        = r_taken;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    for (int ch = 0; ch < 2; ch++) begin
                        n_taken[ch] = 1'b0;
                        if (!w_ok[ch]) begin
                            // Refused: the run restarts, and at the miss
                            // limit the mean and fill are dropped.
                            n_run[ch] = '0;
                            if (r_miss[ch] >= r_miss_limit) begin
                                n_mean[ch] = '0;
                                n_fill[ch] = '0;
                            end else begin
                                n_miss[ch] = r_miss[ch] + 1'b1;
                            end
                        end else begin
                            n_miss[ch] = '0;
                            if (r_run[ch] >= r_run_limit) begin
                                n_taken[ch] = w_jump[ch];
                                n_run[ch]   = w_jump[ch] ? r_run_limit : '0;
                            end else begin
                                n_taken[ch] = 1'b1;
                                n_run[ch]   = r_run[ch] + 1'b1;
                            end
                            if (n_taken[ch]) begin
                                for (int k = 0; k < HISTORY_DEPTH - 1; k++) begin
                                    n_hist[ch][k] = r_hist[ch][k+1];
                                end
                                n_hist[ch][HISTORY_DEPTH-1] = w_val[ch][DATA_W-1:0];
                                if (r_fill[ch] < FILL_W'(HISTORY_DEPTH)) begin
                                    n_fill[ch] = r_fill[ch] + 1'b1;
                                end
                            end
                        end
                    end
                    n_sel   = 1'b0;
                    n_idx   = '0;
                    n_acc   = '0;
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                // Rotate the selected history by one; once every entry has passed the tap
                // it is back in place, and the shifted window sum becomes its mean if taken.
                for (int k = 0; k < HISTORY_DEPTH - 1; k++) begin
                    n_hist[r_sel][k] = r_hist[r_sel][k+1];
                end
                n_hist[r_sel][HISTORY_DEPTH-1] = r_hist[r_sel][0];
                n_acc = w_acc_sum;
                n_idx = r_idx + 1'b1;
                if (w_last) begin
                    if (r_taken[r_sel]) begin
                        n_mean[r_sel] = (w_sh == '0) ? '0 : w_acc_shr[DATA_W-1:0];
                    end
                    n_idx = '0;
                    n_acc = '0;
                    n_sel = 1'b1;
                    if (r_sel) begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid      = 1'b1;
                    n_o_hr_avg     = r_mean[CH_HR];
                    n_o_spo2_avg   = r_mean[CH_SPO2];
                    n_o_hr_taken   = r_taken[CH_HR];
                    n_o_spo2_taken = r_taken[CH_SPO2];
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_sel     <= 1'b0;
            r_idx     <= '0;
            r_o_valid <= 1'b0;
            for (int ch = 0; ch < 2; ch++) begin
                for (int k = 0; k < HISTORY_DEPTH; k++) begin
                    r_hist[ch][k] <= '0;
                end
                r_fill[ch]  <= '0;
                r_run[ch]   <= '0;
                r_miss[ch]  <= '0;
                r_mean[ch]  <= '0;
                r_taken[ch] <= 1'b0;
            end
        end else begin
            r_state   <= n_state;
            r_sel     <= n_sel;
            r_idx     <= n_idx;
            r_o_valid <= n_o_valid;
            r_hist    <= n_hist;
            r_fill    <= n_fill;
            r_run     <= n_run;
            r_miss    <= n_miss;
            r_mean    <= n_mean;
            r_taken   <= n_taken;
        end
    end

    // Accumulator and output payload need no reset.
    always_ff @(posedge i_clk) begin
        r_acc          <= n_acc;
        r_o_hr_avg     <= n_o_hr_avg;
        r_o_spo2_avg   <= n_o_spo2_avg;
        r_o_hr_taken   <= n_o_hr_taken;
        r_o_spo2_taken <= n_o_spo2_taken;
    end

    // Configuration registers; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hr_floor    <= RST_HR_FLOOR;
            r_hr_ceiling  <= RST_HR_CEILING;
            r_spo2_floor  <= RST_SPO2_FLOOR;
            r_jump_margin <= RST_JUMP_MARGIN;
            r_miss_limit  <= RST_MISS_LIMIT;
            r_run_limit   <= RST_RUN_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HR_FLOOR:    r_hr_floor    <= i_cfg_data;
                CFG_HR_CEILING:  r_hr_ceiling  <= i_cfg_data;
                CFG_SPO2_FLOOR:  r_spo2_floor  <= i_cfg_data;
                CFG_JUMP_MARGIN: r_jump_margin <= i_cfg_data;
                CFG_MISS_LIMIT:  r_miss_limit  <= i_cfg_data[LIMIT_W-1:0];
                CFG_RUN_LIMIT:   r_run_limit   <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule
